// File: design/adbdr_pkg.sv
// Shared types and constants for the bus device register responder.
package adbdr_pkg;

	// Item kinds on the request channel
	localparam logic [1:0] ITEM_BUS     = 2'd0;
	localparam logic [1:0] ITEM_PRESS   = 2'd1;
	localparam logic [1:0] ITEM_RELEASE = 2'd2;

	// Bus command field (bits 3:2 of the command byte)
	localparam logic [1:0] BUS_LISTEN = 2'd2;
	localparam logic [1:0] BUS_TALK   = 2'd3;

	// Device register numbers
	localparam logic [1:0] DEV_REG1 = 2'd1;
	localparam logic [1:0] DEV_REG2 = 2'd2;
	localparam logic [1:0] DEV_REG3 = 2'd3;

	// Reset values of the device registers
	localparam logic [7:0]  MOUSE_ADDR_RESET    = 8'h63;
	localparam logic [7:0]  MOUSE_HANDLER_RESET = 8'h01;
	localparam logic [15:0] KBD_LED_MOD_RESET   = 16'hffff;
	localparam logic [7:0]  KBD_ADDR_RESET      = 8'h62;
	localparam logic [7:0]  KBD_TYPE_RESET      = 8'h05;

	// Listen register 3 second-byte codes
	localparam logic [7:0] LISTEN_SET_ADDR = 8'hfe;
	localparam logic [7:0] LISTEN_SET_BITS = 8'h00;
	localparam logic [7:0] ADDR_KEEP_MASK  = 8'hd0;
	localparam logic [7:0] ADDR_SET_MASK   = 8'h2f;

	// Mouse identity answer to talk register 1
	localparam logic [63:0] MOUSE_IDENT = 64'h6170_706c_012c_0103;

	// Modifier key codes
	localparam logic [6:0] KEY_SCROLL = 7'h6b;
	localparam logic [6:0] KEY_NUM    = 7'h47;
	localparam logic [6:0] KEY_CMD    = 7'h37;
	localparam logic [6:0] KEY_OPT    = 7'h3a;
	localparam logic [6:0] KEY_SHIFT  = 7'h38;
	localparam logic [6:0] KEY_CTRL   = 7'h36;
	localparam logic [6:0] KEY_CAPS   = 7'h39;
	localparam logic [6:0] KEY_DEL    = 7'h75;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  bus_op;
		logic [15:0] listen_data;
		logic [6:0]  key_code;
		logic [3:0]  random_nibble;
	} req_t;

	typedef struct packed {
		logic [3:0]  talk_count;
		logic [63:0] talk_data;
		logic [7:0]  mouse_handler_id;
		logic [3:0]  mouse_address;
		logic [3:0]  keyboard_address;
	} rsp_t;

	// Held state of the keys that feed keyboard register 2
	typedef struct packed {
		logic scroll;
		logic num;
		logic cmd;
		logic opt;
		logic shift;
		logic ctrl;
		logic caps;
		logic del;
	} mod_keys_t;

endpackage

// File: design/adbdr_key_matrix.sv
// 128-key up/down matrix with taps for the modifier keys.
module adbdr_key_matrix (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  pressed,
	input  logic [6:0]            key,
	output adbdr_pkg::mod_keys_t  mod_keys
);
	import adbdr_pkg::*;

	logic [127:0] matrix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
		end else if (wr_en) begin
			matrix_q[key] <= pressed;
		end
	end

	assign mod_keys.scroll = matrix_q[KEY_SCROLL];
	assign mod_keys.num    = matrix_q[KEY_NUM];
	assign mod_keys.cmd    = matrix_q[KEY_CMD];
	assign mod_keys.opt    = matrix_q[KEY_OPT];
	assign mod_keys.shift  = matrix_q[KEY_SHIFT];
	assign mod_keys.ctrl   = matrix_q[KEY_CTRL];
	assign mod_keys.caps   = matrix_q[KEY_CAPS];
	assign mod_keys.del    = matrix_q[KEY_DEL];

endmodule

// File: design/adbdr_dev_regs.sv
// Mouse and keyboard device registers, command decode and talk answer.
module adbdr_dev_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  apply,
	input  adbdr_pkg::req_t       req,
	input  logic [7:0]            keyboard_type,
	input  adbdr_pkg::mod_keys_t  mod_keys,
	output adbdr_pkg::rsp_t       rsp
);
	import adbdr_pkg::*;

	logic [7:0]  mouse_addr_q, mouse_addr_d;
	logic [7:0]  mouse_handler_q, mouse_handler_d;
	logic [15:0] kbd_led_mod_q, kbd_led_mod_d;
	logic [7:0]  kbd_addr_q, kbd_addr_d;

	logic [3:0]  adr;
	logic [1:0]  bus_cmd;
	logic [1:0]  dev_reg;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [7:0]  hi;
	logic [7:0]  lo;
	logic [3:0]  count;
	logic [63:0] data;

	function automatic logic [7:0] addr_listen(logic [7:0] cur, logic [7:0] a, logic [7:0] b);
		logic [7:0] res;
		res = cur;
		if (b == LISTEN_SET_ADDR)
			res = {cur[7:4], a[3:0]};
		else if (b == LISTEN_SET_BITS)
			res = (cur & ADDR_KEEP_MASK) | (a & ADDR_SET_MASK);
		return res;
	endfunction

	assign adr     = req.bus_op[7:4];
	assign bus_cmd = req.bus_op[3:2];
	assign dev_reg = req.bus_op[1:0];
	assign b1      = req.listen_data[15:8];
	assign b2      = req.listen_data[7:0];

	// modifier bytes are active low
	always_comb begin
		hi = 8'hff;
		lo = kbd_led_mod_q[7:0] | 8'hf8;
		if (mod_keys.scroll) lo[6] = 1'b0;
		if (mod_keys.num)    lo[7] = 1'b0;
		if (mod_keys.cmd)    hi[0] = 1'b0;
		if (mod_keys.opt)    hi[1] = 1'b0;
		if (mod_keys.shift)  hi[2] = 1'b0;
		if (mod_keys.ctrl)   hi[3] = 1'b0;
		if (mod_keys.caps)   hi[5] = 1'b0;
		if (mod_keys.del)    hi[6] = 1'b0;
	end

	always_comb begin
		mouse_addr_d    = mouse_addr_q;
		mouse_handler_d = mouse_handler_q;
		kbd_led_mod_d   = kbd_led_mod_q;
		kbd_addr_d      = kbd_addr_q;
		count           = 4'd0;
		data            = '0;
		if (req.command == ITEM_BUS) begin
			// mouse address wins when both devices match
			priority if (req.bus_op[3:0] == 4'd0) begin
				mouse_addr_d    = MOUSE_ADDR_RESET;
				mouse_handler_d = MOUSE_HANDLER_RESET;
				kbd_led_mod_d   = KBD_LED_MOD_RESET;
				kbd_addr_d      = KBD_ADDR_RESET;
			end else if (adr == mouse_addr_q[3:0]) begin
				if (bus_cmd == BUS_LISTEN && dev_reg == DEV_REG3) begin
					if (b2 == 8'd1 || b2 == 8'd2 || b2 == 8'd4)
						mouse_handler_d = b2;
					else
						mouse_addr_d = addr_listen(mouse_addr_q, b1, b2);
				end else if (bus_cmd == BUS_TALK && dev_reg == DEV_REG1) begin
					count = 4'd8;
					data  = MOUSE_IDENT;
				end else if (bus_cmd == BUS_TALK && dev_reg == DEV_REG3) begin
					count = 4'd2;
					data  = {mouse_addr_q[7:4], req.random_nibble, mouse_handler_q, 48'd0};
				end
			end else if (adr == kbd_addr_q[3:0]) begin
				if (bus_cmd == BUS_LISTEN && dev_reg == DEV_REG2) begin
					kbd_led_mod_d = req.listen_data;
				end else if (bus_cmd == BUS_LISTEN && dev_reg == DEV_REG3) begin
					kbd_addr_d = addr_listen(kbd_addr_q, b1, b2);
				end else if (bus_cmd == BUS_TALK && dev_reg == DEV_REG2) begin
					count = 4'd2;
					data  = {hi, lo, 48'd0};
				end else if (bus_cmd == BUS_TALK && dev_reg == DEV_REG3) begin
					count = 4'd2;
					data  = {kbd_addr_q[7:4], req.random_nibble, keyboard_type, 48'd0};
				end
			end else begin
				// unknown address: no device answers
				count = 4'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_addr_q    <= MOUSE_ADDR_RESET;
			mouse_handler_q <= MOUSE_HANDLER_RESET;
			kbd_led_mod_q   <= KBD_LED_MOD_RESET;
			kbd_addr_q      <= KBD_ADDR_RESET;
		end else if (apply) begin
			mouse_addr_q    <= mouse_addr_d;
			mouse_handler_q <= mouse_handler_d;
			kbd_led_mod_q   <= kbd_led_mod_d;
			kbd_addr_q      <= kbd_addr_d;
		end
	end

	assign rsp.talk_count       = count;
	assign rsp.talk_data        = data;
	assign rsp.mouse_handler_id = mouse_handler_d;
	assign rsp.mouse_address    = mouse_addr_d[3:0];
	assign rsp.keyboard_address = kbd_addr_d[3:0];

endmodule

// File: design/adb_device_register_responder.sv
// Path: an accepted word goes into the input register and its result into the result register.
// Throughput: one word per cycle unless rsp_ready stalls; each register holds one word.
// Device registers and key matrix update as a word leaves the input register.
// Reset (arst_n low) empties both registers, restores the device registers and
// keyboard type 5, and releases all keys.
module adb_device_register_responder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  adbdr_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output adbdr_pkg::rsp_t  rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);
	import adbdr_pkg::*;

	req_t      req_s1;
	logic      valid_s1;
	rsp_t      rsp_q;
	logic      rsp_valid_q;
	logic [7:0] kbd_type_q;
	logic      advance;
	logic      fire_s1;
	rsp_t      result;
	mod_keys_t mod_keys;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign fire_s1   = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbd_type_q <= KBD_TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			kbd_type_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	adbdr_key_matrix u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fire_s1 && (req_s1.command == ITEM_PRESS ||
		                       req_s1.command == ITEM_RELEASE)),
		.pressed  (req_s1.command == ITEM_PRESS),
		.key      (req_s1.key_code),
		.mod_keys (mod_keys)
	);

	adbdr_dev_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.apply         (fire_s1),
		.req           (req_s1),
		.keyboard_type (kbd_type_q),
		.mod_keys      (mod_keys),
		.rsp           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: dv/tb.sv
// Testbench for the bus device register responder: directed table, then random words.
`timescale 1ns / 100ps

module tb;
	import adbdr_pkg::*;

	localparam logic [1:0] ITEM_NONE = 2'd3;
	localparam logic [1:0] BUS_FLUSH = 2'd0;
	localparam logic [1:0] BUS_RSVD  = 2'd1;
	localparam logic [1:0] DEV_REG0  = 2'd0;
	localparam logic [7:0] MOUSE_HID_STD   = 8'd1;
	localparam logic [7:0] MOUSE_HID_HIRES = 8'd2;
	localparam logic [7:0] MOUSE_HID_EXT   = 8'd4;
	localparam int unsigned RAND_PER_PHASE = 250;
	localparam int unsigned LONG_HOLD = 40;

	typedef struct {
		req_t stim;
		bit   typed;
		rsp_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;

	// device state as the predictor sees it
	logic [7:0]  kbd_type_m;
	logic [7:0]  mouse_addr_m;
	logic [7:0]  mouse_hid_m;
	logic [15:0] led_mod_m;
	logic [7:0]  kbd_addr_m;
	logic        key_down_m [128];

	rsp_t      answers_due [$];
	step_row_t dir_rows [$];
	int unsigned fail_count;
	bit steady;
	bit hold_off_req;

	adb_device_register_responder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void restore_regs();
		mouse_addr_m = MOUSE_ADDR_RESET;
		mouse_hid_m  = MOUSE_HANDLER_RESET;
		led_mod_m    = KBD_LED_MOD_RESET;
		kbd_addr_m   = KBD_ADDR_RESET;
	endfunction

	function automatic logic [7:0] addr_listen(logic [7:0] cur, logic [7:0] b1, logic [7:0] b2);
		if (b2 == LISTEN_SET_ADDR)
			return {cur[7:4], b1[3:0]};
		if (b2 == LISTEN_SET_BITS)
			return (cur & ADDR_KEEP_MASK) | (b1 & ADDR_SET_MASK);
		return cur;
	endfunction

	// Applies one word to the device state and returns the answer it gives.
	function automatic rsp_t predict_answer(req_t r);
		rsp_t a;
		logic [3:0] adr;
		logic [1:0] bcmd;
		logic [1:0] breg;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] hi;
		logic [7:0] lo;
		a = '0;
		adr = r.bus_op[7:4];
		bcmd = r.bus_op[3:2];
		breg = r.bus_op[1:0];
		b1 = r.listen_data[15:8];
		b2 = r.listen_data[7:0];
		case (r.command)
			ITEM_PRESS:   key_down_m[r.key_code] = 1'b1;
			ITEM_RELEASE: key_down_m[r.key_code] = 1'b0;
			ITEM_BUS: begin
				if (r.bus_op[3:0] == 4'h0) begin
					restore_regs();
				end else if (adr == mouse_addr_m[3:0]) begin
					// mouse wins when both devices sit on the same address
					if (bcmd == BUS_LISTEN && breg == DEV_REG3) begin
						if (b2 == MOUSE_HID_STD || b2 == MOUSE_HID_HIRES || b2 == MOUSE_HID_EXT)
							mouse_hid_m = b2;
						else
							mouse_addr_m = addr_listen(mouse_addr_m, b1, b2);
					end else if (bcmd == BUS_TALK && breg == DEV_REG1) begin
						a.talk_count = 4'd8;
						a.talk_data = MOUSE_IDENT;
					end else if (bcmd == BUS_TALK && breg == DEV_REG3) begin
						a.talk_count = 4'd2;
						a.talk_data = {mouse_addr_m[7:4], r.random_nibble, mouse_hid_m, 48'h0};
					end
				end else if (adr == kbd_addr_m[3:0]) begin
					if (bcmd == BUS_LISTEN && breg == DEV_REG2) begin
						led_mod_m = r.listen_data;
					end else if (bcmd == BUS_LISTEN && breg == DEV_REG3) begin
						kbd_addr_m = addr_listen(kbd_addr_m, b1, b2);
					end else if (bcmd == BUS_TALK && breg == DEV_REG2) begin
						hi = 8'hff;
						lo = led_mod_m[7:0] | 8'hf8;
						if (key_down_m[KEY_SCROLL]) lo[6] = 1'b0;
						if (key_down_m[KEY_NUM])    lo[7] = 1'b0;
						if (key_down_m[KEY_CMD])    hi[0] = 1'b0;
						if (key_down_m[KEY_OPT])    hi[1] = 1'b0;
						if (key_down_m[KEY_SHIFT])  hi[2] = 1'b0;
						if (key_down_m[KEY_CTRL])   hi[3] = 1'b0;
						if (key_down_m[KEY_CAPS])   hi[5] = 1'b0;
						if (key_down_m[KEY_DEL])    hi[6] = 1'b0;
						a.talk_count = 4'd2;
						a.talk_data = {hi, lo, 48'h0};
					end else if (bcmd == BUS_TALK && breg == DEV_REG3) begin
						a.talk_count = 4'd2;
						a.talk_data = {kbd_addr_m[7:4], r.random_nibble, kbd_type_m, 48'h0};
					end
				end
			end
			default: ;
		endcase
		a.mouse_handler_id = mouse_hid_m;
		a.mouse_address = mouse_addr_m[3:0];
		a.keyboard_address = kbd_addr_m[3:0];
		return a;
	endfunction

	function automatic req_t mk(logic [1:0] c, logic [7:0] op, logic [15:0] ld, logic [6:0] k,
			logic [3:0] n);
		req_t r;
		r.command = c;
		r.bus_op = op;
		r.listen_data = ld;
		r.key_code = k;
		r.random_nibble = n;
		return r;
	endfunction

	function automatic logic [6:0] pick_key();
		case ($urandom_range(0, 9))
			0: return KEY_SCROLL;
			1: return KEY_NUM;
			2: return KEY_CMD;
			3: return KEY_OPT;
			4: return KEY_SHIFT;
			5: return KEY_CTRL;
			6: return KEY_CAPS;
			7: return KEY_DEL;
			default: return 7'($urandom);
		endcase
	endfunction

	// Mostly commands aimed at a live device address, so listens and talks take effect.
	function automatic req_t rand_item();
		req_t r;
		int unsigned pick;
		r = req_t'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r.command = ITEM_NONE;
		end else if (pick < 30) begin
			r.command = $urandom_range(0, 1) ? ITEM_PRESS : ITEM_RELEASE;
			r.key_code = pick_key();
		end else begin
			r.command = ITEM_BUS;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: r.bus_op[7:4] = mouse_addr_m[3:0];
				4, 5, 6, 7: r.bus_op[7:4] = kbd_addr_m[3:0];
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3: r.bus_op[3:2] = BUS_TALK;
				4, 5, 6, 7: r.bus_op[3:2] = BUS_LISTEN;
				default: ;
			endcase
			if ($urandom_range(0, 2) != 0)
				r.bus_op[1:0] = 2'($urandom_range(1, 3));
			if ($urandom_range(0, 29) == 0)
				r.bus_op[3:0] = 4'h0;
			case ($urandom_range(0, 7))
				0: r.listen_data[7:0] = LISTEN_SET_ADDR;
				1: r.listen_data[7:0] = LISTEN_SET_BITS;
				2: r.listen_data[7:0] = MOUSE_HID_STD;
				3: r.listen_data[7:0] = MOUSE_HID_HIRES;
				4: r.listen_data[7:0] = MOUSE_HID_EXT;
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (answers_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected word %h", got);
		end else begin
			want = answers_due.pop_front();
			if (got.talk_count !== want.talk_count || got.talk_data !== want.talk_data ||
					got.mouse_handler_id !== want.mouse_handler_id ||
					got.mouse_address !== want.mouse_address ||
					got.keyboard_address !== want.keyboard_address) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch: exp cnt=%0d data=%h hid=%h madr=%h kadr=%h",
						want.talk_count, want.talk_data, want.mouse_handler_id,
						want.mouse_address, want.keyboard_address);
					$display("          got cnt=%0d data=%h hid=%h madr=%h kadr=%h",
						got.talk_count, got.talk_data, got.mouse_handler_id,
						got.mouse_address, got.keyboard_address);
				end
			end
		end
	endtask

	// Called at a rising edge; returns at the edge the word is taken.
	task automatic push_item(input req_t r);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic send(input req_t r, input bit typed, input rsp_t want);
		rsp_t a;
		a = predict_answer(r);
		answers_due.push_back(typed ? want : a);
		push_item(r);
		if (!steady && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_kbd_type(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		kbd_type_m = v;
	endtask

	initial begin : rsp_side
		int unsigned stall;
		stall = 0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (hold_off_req) begin
				stall = LONG_HOLD;
				hold_off_req = 1'b0;
			end else if (stall == 0 && !steady && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 8);
			end
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : req_side
		logic [7:0] kb_settings [4];
		rsp_t none;
		none = '0;
		fail_count = 0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		kbd_type_m = KBD_TYPE_RESET;
		restore_regs();
		foreach (key_down_m[i])
			key_down_m[i] = 1'b0;

		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_TALK, DEV_REG1}, 16'h0000, 7'h00, 4'h0), 1'b1,
			rsp_t'{4'd8, 64'h6170_706c_012c_0103, 8'h01, 4'h3, 4'h2}});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_TALK, DEV_REG3}, 16'hffff, 7'h7f, 4'hf), 1'b1,
			rsp_t'{4'd2, 64'h6f01_0000_0000_0000, 8'h01, 4'h3, 4'h2}});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_TALK, DEV_REG3}, 16'h0000, 7'h00, 4'h0), 1'b1,
			rsp_t'{4'd2, 64'h6005_0000_0000_0000, 8'h01, 4'h3, 4'h2}});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_TALK, DEV_REG2}, 16'hffff, 7'h00, 4'h0), 1'b1,
			rsp_t'{4'd2, 64'hffff_0000_0000_0000, 8'h01, 4'h3, 4'h2}});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_SCROLL, 4'h0), 1'b1,
			rsp_t'{4'd0, 64'h0, 8'h01, 4'h3, 4'h2}});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_NUM, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'hff, 16'h0000, KEY_CMD, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_OPT, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_SHIFT, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_CTRL, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_CAPS, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, KEY_DEL, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_TALK, DEV_REG2}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_LISTEN, DEV_REG2}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_RELEASE, 8'h00, 16'h0000, KEY_DEL, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_PRESS, 8'h00, 16'h0000, 7'h7f, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_TALK, DEV_REG2}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_LISTEN, DEV_REG3}, 16'h0002, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_LISTEN, DEV_REG3}, 16'hff00, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'hf, BUS_LISTEN, DEV_REG3}, 16'h05fe, 7'h00, 4'h0), 1'b0, none});
		// keyboard moved onto the mouse address: mouse answers from here on
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_LISTEN, DEV_REG3}, 16'hf5fe, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h5, BUS_TALK, DEV_REG3}, 16'h0000, 7'h00, 4'h9), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h5, BUS_LISTEN, DEV_REG3}, 16'h1277, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h5, BUS_FLUSH, DEV_REG1}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h5, BUS_RSVD, DEV_REG2}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'he, BUS_TALK, DEV_REG3}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_NONE, 8'h00, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, 8'hf0, 16'hffff, 7'h00, 4'h0), 1'b1,
			rsp_t'{4'd0, 64'h0, 8'h01, 4'h3, 4'h2}});
		// key matrix survives bus reset
		dir_rows.push_back('{mk(ITEM_BUS, {4'h2, BUS_TALK, DEV_REG2}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_TALK, DEV_REG0}, 16'h0000, 7'h00, 4'h0), 1'b0, none});
		dir_rows.push_back('{mk(ITEM_BUS, {4'h3, BUS_LISTEN, DEV_REG3}, 16'h0004, 7'h00, 4'h0), 1'b0, none});

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
		settle();

		kb_settings[0] = 8'h00;
		kb_settings[1] = 8'hff;
		kb_settings[2] = 8'($urandom);
		kb_settings[3] = 8'($urandom);
		for (int p = 0; p < 4; p++) begin
			write_kbd_type(kb_settings[p]);
			if (p == 3)
				steady = 1'b1;
			for (int unsigned i = 0; i < RAND_PER_PHASE; i++) begin
				if (p == 1 && i == 50)
					hold_off_req = 1'b1;
				send(rand_item(), 1'b0, none);
			end
			settle();
		end

		repeat (10)
			@(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
